/* design/bbdf_pkg.sv */
// shared constants, types and state encoding for the digit-to-fraction converter
`timescale 1ns / 1ps
`default_nettype none

package bbdf_pkg;

  // fraction format and digit width
  localparam int FRAC_BITS  = 32;
  localparam int DIGIT_BITS = 16;

  // fixed field widths
  localparam int DIGIT_W = 16;
  localparam int BASE_W  = 16;
  localparam int FRAC_W  = 32;

  // dividend of the serial divider must hold 2^FRAC_BITS and any reciprocal
  localparam int DVD_W  = (FRAC_BITS + 1 > FRAC_W) ? FRAC_BITS + 1 : FRAC_W;
  localparam int CNT_W  = $clog2(DVD_W + 1);
  localparam int PROD_W = DIGIT_W + FRAC_W;

  localparam logic [DVD_W-1:0]   RELOAD_DVD = DVD_W'(1) << FRAC_BITS;
  localparam logic [FRAC_W-1:0]  FRAC_MAX   = {FRAC_W{1'b1}};
  localparam logic [BASE_W-1:0]  BASE_MIN   = BASE_W'(2);
  localparam logic [DIGIT_W-1:0] DIGIT_MASK = (DIGIT_BITS >= DIGIT_W) ? {DIGIT_W{1'b1}} :
                                              DIGIT_W'((64'd1 << DIGIT_BITS) - 64'd1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_RELOAD,
    S_MUL,
    S_ACC,
    S_DIV,
    S_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic clear_acc;
    logic div_start;
    logic div_reload;
    logic recip_load;
    logic mul;
    logic acc_upd;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_valid;
    logic first;
    logic last;
    logic div_busy;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* design/bbdf_div.sv */
// restoring bit-serial divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module bbdf_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bbdf_pkg::DVD_W-1:0]  dividend,
  input  logic [bbdf_pkg::BASE_W-1:0] divisor,
  output logic                        busy,
  output logic                        done,
  output logic [bbdf_pkg::DVD_W-1:0]  quotient
);
  import bbdf_pkg::*;

  logic [DVD_W-1:0]  dvd_r;
  logic [DVD_W-1:0]  dvd_nxt;
  logic [BASE_W-1:0] dsr_r;
  logic [BASE_W-1:0] rem_r;
  logic [BASE_W-1:0] rem_nxt;
  logic [BASE_W:0]   rem_sh;
  logic [BASE_W:0]   rem_dif;
  logic              ge;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[DVD_W-1]};
    ge      = (rem_sh >= {1'b0, dsr_r});
    rem_dif = rem_sh - {1'b0, dsr_r};
    rem_nxt = ge ? rem_dif[BASE_W-1:0] : rem_sh[BASE_W-1:0];
    dvd_nxt = {dvd_r[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = dvd_r;

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r)
    else $error("divider not busy after start");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done longer than one cycle");
`endif

endmodule

`default_nettype wire

/* design/bbdf_dp.sv */
// datapath: input word, reciprocal, accumulator, product and output register
`timescale 1ns / 1ps
`default_nettype none

module bbdf_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bbdf_pkg::cmd_t               cmd,
  output bbdf_pkg::sts_t               sts,
  input  logic                         in_valid,
  input  logic [bbdf_pkg::DIGIT_W-1:0] in_digit,
  input  logic [bbdf_pkg::BASE_W-1:0]  in_base,
  input  logic                         in_first_digit,
  input  logic                         in_last_digit,
  output logic [bbdf_pkg::FRAC_W-1:0]  out_fraction,
  output logic                         out_valid,
  input  logic                         out_ready
);
  import bbdf_pkg::*;

  logic [DIGIT_W-1:0] digit_r;
  logic [BASE_W-1:0]  base_r;
  logic               first_r;
  logic               last_r;
  logic [FRAC_W-1:0]  recip_r;
  logic [FRAC_W-1:0]  acc_r;
  logic [PROD_W-1:0]  prod_r;
  logic [FRAC_W-1:0]  out_fraction_r;
  logic               out_valid_r;

  logic [DVD_W-1:0]   dividend;
  logic [DVD_W-1:0]   quotient;
  logic [FRAC_W-1:0]  quot_sat;
  logic [PROD_W:0]    acc_sum;
  logic [FRAC_W-1:0]  acc_sat;
  logic               div_busy;
  logic               div_done;

  assign dividend = cmd.div_reload ? RELOAD_DVD : DVD_W'(recip_r);

  bbdf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (base_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    quot_sat = (quotient > DVD_W'(FRAC_MAX)) ? FRAC_MAX : quotient[FRAC_W-1:0];
    acc_sum  = (PROD_W+1)'(acc_r) + (PROD_W+1)'(prod_r);
    acc_sat  = (|acc_sum[PROD_W:FRAC_W]) ? FRAC_MAX : acc_sum[FRAC_W-1:0];
  end

  // input word capture, product and output data registers; base below two runs as base two
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      digit_r <= in_digit & DIGIT_MASK;
      base_r  <= (in_base < BASE_MIN) ? BASE_MIN : in_base;
      first_r <= in_first_digit;
      last_r  <= in_last_digit;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(digit_r) * PROD_W'(recip_r);
    end
    if (cmd.out_load) begin
      out_fraction_r <= acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recip_r     <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.recip_load) begin
        recip_r <= quot_sat;
      end
      if (cmd.clear_acc) begin
        acc_r <= '0;
      end else if (cmd.acc_upd) begin
        acc_r <= acc_sat;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.in_valid = in_valid;
    sts.first    = first_r;
    sts.last     = last_r;
    sts.div_busy = div_busy;
    sts.div_done = div_done;
    sts.out_free = !out_valid_r || out_ready;
  end

  assign out_fraction = out_fraction_r;
  assign out_valid    = out_valid_r;

`ifndef SYNTHESIS
  a_acc_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.acc_upd && !cmd.clear_acc) |=> (acc_r >= $past(acc_r)))
    else $error("accumulator decreased on a digit update");
`endif

endmodule

`default_nettype wire

/* design/bbdf_ctrl.sv */
// controller state machine sequencing reload, multiply-add and divide
`timescale 1ns / 1ps
`default_nettype none

module bbdf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  bbdf_pkg::sts_t sts,
  output bbdf_pkg::cmd_t cmd,
  output logic           in_ready
);
  import bbdf_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (sts.in_valid) state_nxt = S_START;
      end
      S_START: begin
        state_nxt = sts.first ? S_RELOAD : S_MUL;
      end
      S_RELOAD: begin
        if (sts.div_done) state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_ACC;
      end
      S_ACC: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = sts.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = sts.in_valid;
      end
      S_START: begin
        if (sts.first) begin
          cmd.clear_acc  = 1'b1;
          cmd.div_start  = 1'b1;
          cmd.div_reload = 1'b1;
        end
      end
      S_RELOAD: begin
        cmd.recip_load = sts.div_done;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
      end
      S_ACC: begin
        cmd.acc_upd   = 1'b1;
        cmd.div_start = 1'b1;
      end
      S_DIV: begin
        cmd.recip_load = sts.div_done;
      end
      S_EMIT: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.div_busy)
    else $error("divide started while divider busy");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten before taken");
`endif

endmodule

`default_nettype wire

/* design/base_b_digits_to_fraction.sv */
// top level of the base-b digit expansion to fixed-point fraction converter
`timescale 1ns / 1ps
`default_nettype none

// Takes the base-b digits of one coordinate, most significant first, one
// word per digit, and returns the unsigned Q0.32 fraction sum digit*b^-(t+1)
// as one output word after the digit marked last. A digit marked first
// clears the accumulator and reloads the reciprocal with floor(2^32/base);
// every digit adds digit*reciprocal (saturating at all ones) and then divides
// the reciprocal by base, truncating. A base of 0 or 1 runs as base 2.
// One digit word is worked at a time, paced by the shared restoring divider,
// which produces one quotient bit per cycle over a 33-bit dividend and runs
// once per digit, twice on a first digit. A finished fraction sits in the
// output register, so the next digit is taken while it waits; a last digit
// holds in its final step only if that register is still full.
module base_b_digits_to_fraction (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bbdf_pkg::DIGIT_W-1:0] in_digit,
  input  logic [bbdf_pkg::BASE_W-1:0]  in_base,
  input  logic                         in_first_digit,
  input  logic                         in_last_digit,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bbdf_pkg::FRAC_W-1:0]  out_fraction
);
  import bbdf_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  bbdf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  bbdf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_valid       (in_valid),
    .in_digit       (in_digit),
    .in_base        (in_base),
    .in_first_digit (in_first_digit),
    .in_last_digit  (in_last_digit),
    .out_fraction   (out_fraction),
    .out_valid      (out_valid),
    .out_ready      (out_ready)
  );

endmodule

`default_nettype wire
